// ----- design/banked_memory_map_decoder_defines.svh -----
// assertion macros shared by the decoder
`ifndef BANKED_MEMORY_MAP_DECODER_DEFINES_SVH
`define BANKED_MEMORY_MAP_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BMMD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("decoder check failed");

// next-cycle implication, checked outside reset
`define BMMD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("decoder sequencing check failed");

`endif

// ----- design/bmmd_pkg.sv -----
package bmmd_pkg;

	// default width of the switchable rom bank number
	localparam int RomBankBitsDefault = 9;

	// bus operation codes
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FETCH = 2'd2
	} op_t;

	// decoded target regions
	typedef enum logic [3:0] {
		TGT_ROM  = 4'd0,
		TGT_VRAM = 4'd1,
		TGT_XRAM = 4'd2,
		TGT_WRAM = 4'd3,
		TGT_OAM  = 4'd4,
		TGT_IO   = 4'd5,
		TGT_HRAM = 4'd6,
		TGT_CART = 4'd7,
		TGT_NONE = 4'd8
	} target_t;

	// region boundaries and masks
	localparam logic [15:0] AddrIe      = 16'hFFFF;
	localparam logic [15:0] AddrHram    = 16'hFF80;
	localparam logic [15:0] AddrIo      = 16'hFF00;
	localparam logic [15:0] AddrOam     = 16'hFE00;
	localparam logic [15:0] AddrUnmap   = 16'hFEA0;
	localparam logic [7:0]  IeMask      = 8'h1F;
	localparam logic [7:0]  IeIoOffset  = 8'hFF;
	localparam logic [1:0]  LcdModeXfer = 2'd3;

	// one cpu access request
	typedef struct packed {
		op_t         operation;
		logic [15:0] address;
		logic [7:0]  write_value;
		logic [8:0]  rom_bank;
		logic [2:0]  wram_bank;
		logic        vram_bank;
		logic [1:0]  lcd_mode;
	} req_t;

	// one decoded result
	typedef struct packed {
		target_t     target;
		logic [22:0] physical_offset;
		logic [7:0]  store_value;
		logic        fill_ff;
		logic        fetch_error;
		logic        oam_changed;
		logic        event_reset;
	} res_t;

endpackage

// ----- design/bmmd_decode.sv -----
module bmmd_decode #(
	parameter int ROM_BANK_BITS = bmmd_pkg::RomBankBitsDefault
) (
	input  bmmd_pkg::req_t req,
	input  logic           colour_mode,
	output bmmd_pkg::res_t res
);

	localparam logic [8:0] RomBankMask = 9'((1 << ROM_BANK_BITS) - 1);

	always_comb begin
		logic        rd;
		logic        wr;
		logic        fetch;
		logic [3:0]  nib;
		logic [2:0]  wbank;
		logic        vbank;
		logic [7:0]  sv;
		logic [8:0]  rb;
		logic [15:0] a;
		a     = req.address;
		nib   = a[15:12];
		rd    = (req.operation == bmmd_pkg::OP_READ);
		wr    = (req.operation == bmmd_pkg::OP_WRITE);
		fetch = (req.operation == bmmd_pkg::OP_FETCH);
		sv    = wr ? req.write_value : 8'd0;
		rb    = req.rom_bank & RomBankMask;
		// monochrome forces wram bank 1 and vram bank 0
		wbank = colour_mode ? ((req.wram_bank != 3'd0) ? req.wram_bank : 3'd1) : 3'd1;
		vbank = colour_mode ? req.vram_bank : 1'b0;

		res             = '0;
		res.target      = bmmd_pkg::TGT_NONE;

		// region decode, order matters in the top page
		priority if (!(rd || wr || fetch)) begin
			res.target = bmmd_pkg::TGT_NONE;
		end else if (nib < 4'h8) begin
			if (wr) begin
				res.target          = bmmd_pkg::TGT_CART;
				res.physical_offset = {7'd0, a};
				res.store_value     = sv;
			end else if (nib < 4'h4) begin
				res.target          = bmmd_pkg::TGT_ROM;
				res.physical_offset = {7'd0, a};
			end else begin
				res.target          = bmmd_pkg::TGT_ROM;
				res.physical_offset = {rb, a[13:0]};
			end
		end else if (nib < 4'hA) begin
			if (fetch) begin
				res.fetch_error = 1'b1;
			end else if (rd && req.lcd_mode == bmmd_pkg::LcdModeXfer) begin
				res.fill_ff = 1'b1;
			end else begin
				res.target          = bmmd_pkg::TGT_VRAM;
				res.physical_offset = {9'd0, vbank, a[12:0]};
				res.store_value     = sv;
			end
		end else if (nib < 4'hC) begin
			if (fetch) begin
				res.fetch_error = 1'b1;
			end else begin
				res.target          = bmmd_pkg::TGT_XRAM;
				res.physical_offset = {10'd0, a[12:0]};
				res.store_value     = sv;
			end
		end else if (nib == 4'hC || nib == 4'hE) begin
			res.target          = bmmd_pkg::TGT_WRAM;
			res.physical_offset = {11'd0, a[11:0]};
			res.store_value     = sv;
		end else if (nib == 4'hD) begin
			res.target          = bmmd_pkg::TGT_WRAM;
			res.physical_offset = {8'd0, wbank, a[11:0]};
			res.store_value     = sv;
		end else if (a == bmmd_pkg::AddrIe && wr) begin
			res.target          = bmmd_pkg::TGT_IO;
			res.physical_offset = {15'd0, bmmd_pkg::IeIoOffset};
			res.store_value     = req.write_value & bmmd_pkg::IeMask;
			res.event_reset     = 1'b1;
		end else if (a >= bmmd_pkg::AddrHram) begin
			res.target          = bmmd_pkg::TGT_HRAM;
			res.physical_offset = {16'd0, a[6:0]};
			res.store_value     = sv;
		end else if (a < bmmd_pkg::AddrOam) begin
			res.target          = bmmd_pkg::TGT_WRAM;
			res.physical_offset = {8'd0, wbank, a[11:0]};
			res.store_value     = sv;
		end else if (fetch) begin
			res.fetch_error = 1'b1;
		end else if (a >= bmmd_pkg::AddrIo) begin
			res.target          = bmmd_pkg::TGT_IO;
			res.physical_offset = {15'd0, a[7:0]};
			res.store_value     = sv;
		end else if (a < bmmd_pkg::AddrUnmap) begin
			res.target          = bmmd_pkg::TGT_OAM;
			res.physical_offset = {15'd0, a[7:0]};
			res.store_value     = sv;
			res.oam_changed     = wr;
		end else begin
			res.fill_ff = rd;
		end
	end

endmodule

// ----- design/banked_memory_map_decoder.sv -----
// a request taken into the request register is decoded into the result register and shows on the ports with done
// throughput: one request per cycle, busy never rises; set by the request and result registers around decode
// the receiver cannot stall, every result stands for exactly one cycle
// reset clears colour_mode to monochrome and drops all pending requests
`include "banked_memory_map_decoder_defines.svh"

module banked_memory_map_decoder #(
	parameter int ROM_BANK_BITS = bmmd_pkg::RomBankBitsDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bmmd_pkg::req_t req,
	output logic           done,
	output bmmd_pkg::res_t result,
	input  logic           cfg_we,
	input  logic           cfg_wdata
);

	logic           colour_mode_q;
	logic           valid_s1;
	bmmd_pkg::req_t req_s1;
	logic           valid_s2;
	bmmd_pkg::res_t res_s2;
	bmmd_pkg::res_t res_d;

	assign busy = 1'b0;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_mode_q <= 1'b0;
		end else if (cfg_we) begin
			colour_mode_q <= cfg_wdata;
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	// address decode
	bmmd_decode #(
		.ROM_BANK_BITS(ROM_BANK_BITS)
	) u_decode (
		.req        (req_s1),
		.colour_mode(colour_mode_q),
		.res        (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res_d;
		end
	end

	assign done   = valid_s2;
	assign result = res_s2;

	// checks
	`BMMD_ASSERT_NEXT(a_done_follows, start && !busy, valid_s1)
	`BMMD_ASSERT_NOW(a_none_zero_offset, done && result.target == bmmd_pkg::TGT_NONE,
		result.physical_offset == 23'd0)
	`BMMD_ASSERT_NOW(a_fetch_err_none, done && result.fetch_error,
		result.target == bmmd_pkg::TGT_NONE && !result.fill_ff)
	`BMMD_ASSERT_NOW(a_ie_masked, done && result.event_reset,
		result.target == bmmd_pkg::TGT_IO && result.store_value[7:5] == 3'd0)

endmodule

// ----- verif/tb_banked_memory_map_decoder.sv -----
module tb_banked_memory_map_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import bmmd_pkg::*;

	// region boundaries that random addresses cluster around
	localparam logic [15:0] RegionEdges [12] = '{
		16'h0000, 16'h4000, 16'h8000, 16'hA000, 16'hC000, 16'hD000,
		16'hE000, 16'hF000, 16'hFE00, 16'hFEA0, 16'hFF00, 16'hFF80
	};
	localparam op_t OpUndefined = op_t'(2'd3);

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	res_t result;
	logic cfg_we;
	logic cfg_wdata;

	int colour_writes;
	int directed_count;

	// expected decodes kept in request order
	class decode_scoreboard;
		res_t decoded_queue[$];
		bit   colour_mode;
		int   mismatches;
		int   checked;

		// decode one bus access under the current colour mode
		function res_t decode_access(req_t r);
			res_t       d;
			logic [3:0] nib;
			logic [2:0] wbank;
			logic       vbank;
			logic       rd;
			logic       wr;
			logic       fetch;
			logic [7:0] sv;
			d = '0;
			d.target = TGT_NONE;
			nib = r.address[15:12];
			rd = (r.operation == OP_READ);
			wr = (r.operation == OP_WRITE);
			fetch = (r.operation == OP_FETCH);
			sv = wr ? r.write_value : 8'h00;
			// bank zero selects bank one, monochrome pins the banks
			wbank = colour_mode ? ((r.wram_bank != 3'd0) ? r.wram_bank : 3'd1) : 3'd1;
			vbank = colour_mode ? r.vram_bank : 1'b0;
			if (!(rd || wr || fetch)) begin
				return d;
			end
			if (nib < 4'h8) begin
				// rom space, writes go to the cartridge registers
				if (wr) begin
					d.target = TGT_CART;
					d.physical_offset = 23'(r.address);
					d.store_value = sv;
				end else if (nib < 4'h4) begin
					d.target = TGT_ROM;
					d.physical_offset = 23'(r.address);
				end else begin
					d.target = TGT_ROM;
					d.physical_offset = {r.rom_bank, r.address[13:0]};
				end
			end else if (nib < 4'hA) begin
				// vram, reads blocked during pixel transfer
				if (fetch) begin
					d.fetch_error = 1'b1;
				end else if (rd && r.lcd_mode == LcdModeXfer) begin
					d.fill_ff = 1'b1;
				end else begin
					d.target = TGT_VRAM;
					d.physical_offset = 23'({vbank, r.address[12:0]});
					d.store_value = sv;
				end
			end else if (nib < 4'hC) begin
				if (fetch) begin
					d.fetch_error = 1'b1;
				end else begin
					d.target = TGT_XRAM;
					d.physical_offset = 23'(r.address - 16'hA000);
					d.store_value = sv;
				end
			end else if (nib == 4'hC || nib == 4'hE) begin
				// fixed wram bank and its echo
				d.target = TGT_WRAM;
				d.physical_offset = 23'(r.address[11:0]);
				d.store_value = sv;
			end else if (nib == 4'hD) begin
				d.target = TGT_WRAM;
				d.physical_offset = 23'({wbank, r.address[11:0]});
				d.store_value = sv;
			end else if (r.address == AddrIe && wr) begin
				// interrupt enable write lands in io space
				d.target = TGT_IO;
				d.physical_offset = 23'(IeIoOffset);
				d.store_value = r.write_value & IeMask;
				d.event_reset = 1'b1;
			end else if (r.address >= AddrHram) begin
				d.target = TGT_HRAM;
				d.physical_offset = 23'(r.address - AddrHram);
				d.store_value = sv;
			end else if (r.address < AddrOam) begin
				// echo of the switchable wram bank
				d.target = TGT_WRAM;
				d.physical_offset = 23'({wbank, r.address[11:0]});
				d.store_value = sv;
			end else if (fetch) begin
				d.fetch_error = 1'b1;
			end else if (r.address >= AddrIo) begin
				d.target = TGT_IO;
				d.physical_offset = 23'(r.address - AddrIo);
				d.store_value = sv;
			end else if (r.address < AddrUnmap) begin
				d.target = TGT_OAM;
				d.physical_offset = 23'(r.address - AddrOam);
				d.store_value = sv;
				d.oam_changed = wr;
			end else begin
				d.fill_ff = rd;
			end
			return d;
		endfunction

		function void note_request(req_t r);
			decoded_queue.push_back(decode_access(r));
		endfunction

		function void compare_field(string name, logic [22:0] want, logic [22:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %h actual %h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (decoded_queue.size() == 0) begin
				$display("%0t: result with no request waiting, target %0d offset %h",
					$time, got.target, got.physical_offset);
				mismatches++;
				return;
			end
			want = decoded_queue.pop_front();
			checked++;
			compare_field("target", 23'(want.target), 23'(got.target));
			compare_field("physical_offset", want.physical_offset, got.physical_offset);
			compare_field("store_value", 23'(want.store_value), 23'(got.store_value));
			compare_field("fill_ff", 23'(want.fill_ff), 23'(got.fill_ff));
			compare_field("fetch_error", 23'(want.fetch_error), 23'(got.fetch_error));
			compare_field("oam_changed", 23'(want.oam_changed), 23'(got.oam_changed));
			compare_field("event_reset", 23'(want.event_reset), 23'(got.event_reset));
		endfunction
	endclass

	decode_scoreboard sb = new;

	banked_memory_map_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// sample accepted requests, register writes and results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				sb.colour_mode = cfg_wdata;
			end
			if (start && !busy) begin
				sb.note_request(req);
			end
			if (done === 1'b1) begin
				sb.check_result(result);
			end
		end
	end

	function automatic req_t make_req(op_t op, logic [15:0] a, logic [7:0] wv,
		logic [8:0] rb, logic [2:0] wb, logic vb, logic [1:0] mode);
		req_t r;
		r.operation = op;
		r.address = a;
		r.write_value = wv;
		r.rom_bank = rb;
		r.wram_bank = wb;
		r.vram_bank = vb;
		r.lcd_mode = mode;
		return r;
	endfunction

	// random access, addresses weighted toward region edges and the top page
	function automatic req_t random_request();
		req_t r;
		int   pick;
		pick = $urandom_range(0, 15);
		r.operation = (pick == 0) ? OpUndefined : op_t'(2'(pick % 3));
		case ($urandom_range(0, 9))
			0, 1, 2, 3: r.address = 16'($urandom);
			4, 5: r.address = RegionEdges[$urandom_range(0, 11)]
				+ 16'($urandom_range(0, 3)) - 16'($urandom_range(0, 3));
			6: r.address = 16'($urandom_range(16'hFE00, 16'hFFFF));
			7: r.address = 16'hFFFF;
			default: r.address = {4'($urandom_range(8, 15)), 12'($urandom)};
		endcase
		r.write_value = 8'($urandom);
		r.rom_bank = 9'($urandom);
		r.wram_bank = 3'($urandom);
		r.vram_bank = 1'($urandom);
		r.lcd_mode = 2'($urandom);
		return r;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int random_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) begin
			return 0;
		end else if (p < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// idle for gap cycles with junk on the bus, then hold the request until taken
	task automatic send_request(req_t r, int gap);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
			req <= random_request();
		end
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		do begin
			@(posedge clk);
		end while (busy);
	endtask

	task automatic wait_drained();
		while (sb.decoded_queue.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// colour mode changes only with the pipeline empty
	task automatic set_colour(bit v);
		@(negedge clk);
		start <= 1'b0;
		wait_drained();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		colour_writes++;
	endtask

	task automatic run_random(int n);
		int burst_left;
		int gap;
		burst_left = 0;
		for (int i = 0; i < n; i++) begin
			if (burst_left == 0 && $urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(20, 60);
			end
			if (burst_left > 0) begin
				gap = 0;
				burst_left--;
			end else begin
				gap = random_gap();
			end
			send_request(random_request(), gap);
		end
	endtask

	// region edges, bank extremes and every special decode
	task automatic run_directed();
		req_t list[$];
		list.push_back(make_req(OP_READ, 16'h0000, 8'h00, 9'd0, 3'd0, 1'b0, 2'd0));
		list.push_back(make_req(OP_FETCH, 16'h3FFF, 8'hFF, 9'd511, 3'd7, 1'b1, 2'd3));
		list.push_back(make_req(OP_READ, 16'h4000, 8'h00, 9'd0, 3'd1, 1'b0, 2'd0));
		list.push_back(make_req(OP_FETCH, 16'h7FFF, 8'h00, 9'd511, 3'd2, 1'b0, 2'd1));
		list.push_back(make_req(OP_WRITE, 16'h7FFF, 8'hFF, 9'd511, 3'd0, 1'b1, 2'd0));
		list.push_back(make_req(OP_WRITE, 16'h0000, 8'h00, 9'd0, 3'd0, 1'b0, 2'd0));
		list.push_back(make_req(OP_READ, 16'h8000, 8'h00, 9'd3, 3'd0, 1'b1, 2'd3));
		list.push_back(make_req(OP_READ, 16'h9FFF, 8'h00, 9'd3, 3'd0, 1'b1, 2'd0));
		list.push_back(make_req(OP_WRITE, 16'h8000, 8'hA5, 9'd3, 3'd0, 1'b1, 2'd3));
		list.push_back(make_req(OP_FETCH, 16'h9FFF, 8'h00, 9'd0, 3'd0, 1'b0, 2'd2));
		list.push_back(make_req(OP_FETCH, 16'hA000, 8'h00, 9'd0, 3'd0, 1'b0, 2'd0));
		list.push_back(make_req(OP_READ, 16'hBFFF, 8'h00, 9'd0, 3'd0, 1'b0, 2'd3));
		list.push_back(make_req(OP_WRITE, 16'hA000, 8'h3C, 9'd0, 3'd0, 1'b0, 2'd0));
		list.push_back(make_req(OP_WRITE, 16'hC000, 8'h5A, 9'd0, 3'd5, 1'b0, 2'd0));
		list.push_back(make_req(OP_READ, 16'hD000, 8'h00, 9'd0, 3'd0, 1'b0, 2'd0));
		list.push_back(make_req(OP_READ, 16'hDFFF, 8'h00, 9'd0, 3'd7, 1'b1, 2'd0));
		list.push_back(make_req(OP_FETCH, 16'hE000, 8'h00, 9'd0, 3'd7, 1'b0, 2'd0));
		list.push_back(make_req(OP_READ, 16'hFDFF, 8'h00, 9'd0, 3'd7, 1'b0, 2'd0));
		list.push_back(make_req(OP_WRITE, 16'hFE00, 8'h81, 9'd0, 3'd0, 1'b0, 2'd3));
		list.push_back(make_req(OP_READ, 16'hFE9F, 8'h00, 9'd0, 3'd0, 1'b0, 2'd0));
		list.push_back(make_req(OP_READ, 16'hFEA0, 8'h00, 9'd0, 3'd0, 1'b0, 2'd0));
		list.push_back(make_req(OP_WRITE, 16'hFEFF, 8'hFF, 9'd0, 3'd0, 1'b0, 2'd0));
		list.push_back(make_req(OP_FETCH, 16'hFE00, 8'h00, 9'd0, 3'd0, 1'b0, 2'd0));
		list.push_back(make_req(OP_FETCH, 16'hFF7F, 8'h00, 9'd0, 3'd0, 1'b0, 2'd0));
		list.push_back(make_req(OP_READ, 16'hFF00, 8'h00, 9'd0, 3'd0, 1'b0, 2'd0));
		list.push_back(make_req(OP_FETCH, 16'hFF80, 8'h00, 9'd0, 3'd0, 1'b0, 2'd0));
		list.push_back(make_req(OP_WRITE, 16'hFFFF, 8'hFF, 9'd0, 3'd0, 1'b0, 2'd0));
		list.push_back(make_req(OP_READ, 16'hFFFF, 8'h00, 9'd0, 3'd0, 1'b0, 2'd0));
		list.push_back(make_req(OpUndefined, 16'hFFFF, 8'hFF, 9'd511, 3'd7, 1'b1, 2'd3));
		foreach (list[i]) begin
			send_request(list[i], i % 2);
		end
		directed_count = list.size();
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		colour_writes = 0;
		directed_count = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// monochrome from reset, then alternate both modes
		run_random(150);
		set_colour(1'b1);
		run_directed();
		run_random(300);
		set_colour(1'b0);
		run_random(300);
		set_colour(1'b1);
		run_random(300);
		set_colour(1'b0);
		run_random(250);

		@(negedge clk);
		start <= 1'b0;
		for (int k = 0; k < 200 && sb.decoded_queue.size() != 0; k++) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
		if (sb.decoded_queue.size() != 0) begin
			$display("%0t: %0d decoded results never arrived", $time, sb.decoded_queue.size());
			sb.mismatches += sb.decoded_queue.size();
		end

		$display("checked %0d decoded requests, %0d of them directed, over %0d mode writes",
			sb.checked, directed_count, colour_writes);
		$display("covered all regions, bank extremes, blocked vram, echo and interrupt enable");
		if (sb.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("%0t: run did not finish in time", $time);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
